// ===== design/vpou_pkg.sv =====
package vpou_pkg;

  localparam int NUM_PARMS   = 64;
  localparam int ADDR_W      = $clog2(NUM_PARMS);
  localparam int LANES       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS   = 48;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam logic [3:0]        FULL_MASK = 4'hF;
  localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
  localparam logic signed [31:0] Q16_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN  = 32'sh8000_0000;

  localparam logic [4:0] OP_CONST_ALL = 5'd0;
  localparam logic [4:0] OP_CONST_MSK = 5'd1;
  localparam logic [4:0] OP_MOVE_ALL  = 5'd2;
  localparam logic [4:0] OP_MOVE_MSK  = 5'd3;
  localparam logic [4:0] OP_SWIZZLE   = 5'd4;
  localparam logic [4:0] OP_ADD       = 5'd5;
  localparam logic [4:0] OP_SUB       = 5'd6;
  localparam logic [4:0] OP_MUL       = 5'd7;
  localparam logic [4:0] OP_DOT3      = 5'd8;
  localparam logic [4:0] OP_DOT4      = 5'd9;
  localparam logic [4:0] OP_DIV       = 5'd10;
  localparam logic [4:0] OP_MOD       = 5'd11;
  localparam logic [4:0] OP_GT        = 5'd12;
  localparam logic [4:0] OP_GE        = 5'd13;
  localparam logic [4:0] OP_LT        = 5'd14;
  localparam logic [4:0] OP_LE        = 5'd15;
  localparam logic [4:0] OP_EQ        = 5'd16;
  localparam logic [4:0] OP_NE        = 5'd17;
  localparam logic [4:0] OP_AND       = 5'd18;
  localparam logic [4:0] OP_OR        = 5'd19;
  localparam logic [4:0] OP_TABLE     = 5'd20;

  typedef logic signed [31:0] q16_t;
  typedef q16_t [LANES-1:0] vec_t;

  typedef enum logic [2:0] {
    CL_CONST, CL_MOVE, CL_SWZ, CL_LANE, CL_MUL, CL_DOT, CL_DIV, CL_TABLE
  } op_class_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RA, B_RB, B_RD, B_EXEC, B_MUL, B_ACC, B_DIV, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [3:0]  lane_mask;
    logic [5:0]  dest_index;
    logic [6:0]  src_a_index;
    logic [6:0]  src_b_index;
    logic [7:0]  swizzle_select;
    q16_t        const_x;
    q16_t        const_y;
    q16_t        const_z;
    q16_t        const_w;
  } vpou_req_t;

  typedef struct packed {
    logic [5:0] written_index;
    q16_t       result_x;
    q16_t       result_y;
    q16_t       result_z;
    q16_t       result_w;
  } vpou_rsp_t;

  typedef struct packed {
    op_class_t         cls;
    logic [4:0]        opcode;
    logic [3:0]        mask;
    logic [5:0]        dest_index;
    logic [ADDR_W-1:0] dest_addr;
    logic              dest_ok;
    logic [ADDR_W-1:0] a_addr;
    logic              a_ok;
    logic [ADDR_W-1:0] b_addr;
    logic              b_ok;
    logic [7:0]        sel;
    vec_t              konst;
  } vpou_cmd_t;

  function automatic q16_t sat_wide(input logic signed [50:0] v);
    if (v > 51'(Q16_MAX)) return Q16_MAX;
    if (v < 51'(Q16_MIN)) return Q16_MIN;
    return v[31:0];
  endfunction

  // lane-wise ops that need no multiplier or divider; unknown codes give zero
  function automatic q16_t lane_simple(input logic [4:0] op, input q16_t a, input q16_t b);
    logic signed [50:0] wa;
    logic signed [50:0] wb;
    wa = 51'(a);
    wb = 51'(b);
    case (op)
      OP_ADD:  return sat_wide(wa + wb);
      OP_SUB:  return sat_wide(wa - wb);
      OP_GT:   return (a > b) ? ONE_Q16 : '0;
      OP_GE:   return (a >= b) ? ONE_Q16 : '0;
      OP_LT:   return (a < b) ? ONE_Q16 : '0;
      OP_LE:   return (a <= b) ? ONE_Q16 : '0;
      OP_EQ:   return (a == b) ? ONE_Q16 : '0;
      OP_NE:   return (a != b) ? ONE_Q16 : '0;
      OP_AND:  return (a != 0 && b != 0) ? ONE_Q16 : '0;
      OP_OR:   return (a != 0 || b != 0) ? ONE_Q16 : '0;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== design/vpou_req_if.sv =====
interface vpou_req_if import vpou_pkg::*; ();
  logic      valid;
  logic      ready;
  vpou_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/vpou_rsp_if.sv =====
interface vpou_rsp_if import vpou_pkg::*; ();
  logic      valid;
  logic      ready;
  vpou_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/vpou_ram.sv =====
module vpou_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/vpou_div.sv =====
module vpou_div import vpou_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic is_mod,
  input  q16_t a,
  input  q16_t b,
  output logic done,
  output q16_t result
);
  // restoring divide, one quotient bit per cycle
  logic [47:0]       dvd;
  logic [32:0]       rem;
  logic [32:0]       dvsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              neg_q;
  logic              neg_r;
  logic              zero;
  logic              mode_mod;
  logic [31:0]       mag_a;
  logic [31:0]       mag_b;
  logic [32:0]       trial;
  logic              ge;

  assign mag_a = a[31] ? 32'(-a) : 32'(a);
  assign mag_b = b[31] ? 32'(-b) : 32'(b);
  assign trial = {rem[31:0], dvd[47]};
  assign ge    = trial >= dvsr;
  assign done  = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == DCNT_W'(DIV_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= is_mod ? {16'b0, mag_a} : {mag_a, 16'b0};
      dvsr     <= {1'b0, mag_b};
      rem      <= '0;
      cnt      <= '0;
      neg_q    <= a[31] ^ b[31];
      neg_r    <= a[31];
      zero     <= (b == 0);
      mode_mod <= is_mod;
    end else if (busy) begin
      rem <= ge ? trial - dvsr : trial;
      dvd <= {dvd[46:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    if (zero) begin
      result = '0;
    end else if (mode_mod) begin
      result = neg_r ? -q16_t'(rem[31:0]) : q16_t'(rem[31:0]);
    end else if (!neg_q) begin
      result = (dvd > 48'h0000_7FFF_FFFF) ? Q16_MAX : q16_t'(dvd[31:0]);
    end else begin
      result = (dvd > 48'h0000_8000_0000) ? Q16_MIN : -q16_t'(dvd[31:0]);
    end
  end
endmodule

// ===== design/vpou_front.sv =====
module vpou_front import vpou_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  vpou_req_if.sink  req,
  output vpou_cmd_t cmd,
  output logic      cmd_valid,
  input  logic      cmd_pop
);
  vpou_cmd_t         queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  vpou_cmd_t         dec;

  assign req.ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push      = req.valid && req.ready;
  assign cmd_valid = count != '0;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_comb begin
    dec.opcode     = req.payload.opcode;
    dec.dest_index = req.payload.dest_index;
    dec.dest_addr  = ADDR_W'(req.payload.dest_index);
    dec.dest_ok    = 32'(req.payload.dest_index) < NUM_PARMS;
    dec.a_addr     = ADDR_W'(req.payload.src_a_index);
    dec.a_ok       = 32'(req.payload.src_a_index) < NUM_PARMS;
    dec.b_addr     = ADDR_W'(req.payload.src_b_index);
    dec.b_ok       = 32'(req.payload.src_b_index) < NUM_PARMS;
    dec.sel        = req.payload.swizzle_select;
    dec.konst      = {req.payload.const_w, req.payload.const_z,
                      req.payload.const_y, req.payload.const_x};
    if (req.payload.opcode inside {OP_CONST_ALL, OP_MOVE_ALL} ||
        req.payload.lane_mask == 4'b0) begin
      dec.mask = FULL_MASK;
    end else begin
      dec.mask = req.payload.lane_mask;
    end
    case (req.payload.opcode) inside
      OP_CONST_ALL, OP_CONST_MSK: dec.cls = CL_CONST;
      OP_MOVE_ALL, OP_MOVE_MSK:   dec.cls = CL_MOVE;
      OP_SWIZZLE:                 dec.cls = CL_SWZ;
      OP_MUL:                     dec.cls = CL_MUL;
      OP_DOT3, OP_DOT4:           dec.cls = CL_DOT;
      OP_DIV, OP_MOD:             dec.cls = CL_DIV;
      OP_TABLE:                   dec.cls = CL_TABLE;
      default:                    dec.cls = CL_LANE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end
endmodule

// ===== design/vpou_back.sv =====
module vpou_back import vpou_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  vpou_cmd_t  cmd_in,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  vpou_rsp_if.source rsp
);
  back_state_t       state;
  back_state_t       state_next;
  vpou_cmd_t         cmd;
  logic [NUM_PARMS-1:0] valid;
  logic [ADDR_W-1:0] raddr;
  vec_t              rdata;
  logic              live;
  vec_t              a_q;
  vec_t              b_q;
  vec_t              d_q;
  vec_t              c_q;
  vec_t              c_simple;
  vec_t              res;
  logic [1:0]        cnt;
  logic [1:0]        last_lane;
  logic signed [63:0] prod;
  logic signed [47:0] rnd;
  logic signed [50:0] acc;
  logic signed [50:0] acc_sum;
  logic              out_free;
  logic              finish;
  logic              div_start;
  logic [LANES-1:0]  div_done;
  vec_t              div_res;

  vpou_ram #(.WIDTH($bits(vec_t)), .DEPTH(NUM_PARMS)) u_ram (
    .clk   (clk),
    .we    (finish && cmd.dest_ok),
    .waddr (cmd.dest_addr),
    .wdata (res),
    .raddr (raddr),
    .rdata (rdata)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vpou_div u_div (
      .clk    (clk),
      .rst    (rst),
      .start  (div_start),
      .is_mod (cmd.opcode == OP_MOD),
      .a      (a_q[i]),
      .b      (b_q[i]),
      .done   (div_done[i]),
      .result (div_res[i])
    );
  end

  assign out_free  = !rsp.valid || rsp.ready;
  assign last_lane = (cmd.cls == CL_DOT && cmd.opcode == OP_DOT3) ? 2'd2 : 2'd3;
  assign rnd       = 48'((prod + 64'sd32768) >>> 16);
  assign acc_sum   = acc + 51'(rnd);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      res[i] = cmd.mask[i] ? c_q[i] : d_q[i];
      case (cmd.cls)
        CL_CONST: c_simple[i] = cmd.konst[i];
        CL_MOVE:  c_simple[i] = a_q[i];
        CL_SWZ:   c_simple[i] = a_q[cmd.sel[2*i +: 2]];
        CL_TABLE: c_simple[i] = b_q[i];
        default:  c_simple[i] = lane_simple(cmd.opcode, a_q[i], b_q[i]);
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (cmd_valid) state_next = B_RA;
      B_RA:   state_next = B_RB;
      B_RB:   state_next = B_RD;
      B_RD:   state_next = B_EXEC;
      B_EXEC: begin
        case (cmd.cls)
          CL_MUL, CL_DOT: state_next = B_MUL;
          CL_DIV:         state_next = B_DIV;
          default:        state_next = B_DONE;
        endcase
      end
      B_MUL:  state_next = B_ACC;
      B_ACC:  state_next = (cnt == last_lane) ? B_DONE : B_MUL;
      B_DIV:  if (&div_done) state_next = B_DONE;
      B_DONE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = 1'b0;
    div_start = 1'b0;
    finish    = 1'b0;
    raddr     = cmd.a_addr;
    case (state)
      B_IDLE: cmd_pop = cmd_valid;
      B_RA:   raddr = cmd.a_addr;
      B_RB:   raddr = cmd.b_addr;
      B_RD:   raddr = cmd.dest_addr;
      B_EXEC: div_start = (cmd.cls == CL_DIV);
      B_DONE: finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      valid     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish && cmd.dest_ok) begin
        valid[cmd.dest_addr] <= 1'b1;
      end
      if (finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (cmd_valid) cmd <= cmd_in;
      B_RA:   live <= cmd.a_ok && valid[cmd.a_addr];
      B_RB: begin
        a_q  <= live ? rdata : '0;
        live <= cmd.b_ok && valid[cmd.b_addr];
      end
      B_RD: begin
        b_q  <= live ? rdata : '0;
        live <= cmd.dest_ok && valid[cmd.dest_addr];
      end
      B_EXEC: begin
        d_q <= live ? rdata : '0;
        c_q <= c_simple;
        cnt <= '0;
        acc <= '0;
      end
      B_MUL:  prod <= a_q[cnt] * b_q[cnt];
      B_ACC: begin
        if (cmd.cls == CL_DOT) begin
          acc <= acc_sum;
          if (cnt == last_lane) begin
            for (int i = 0; i < LANES; i++) c_q[i] <= sat_wide(acc_sum);
          end
        end else begin
          c_q[cnt] <= sat_wide(51'(rnd));
        end
        cnt <= cnt + 1'b1;
      end
      B_DIV:  if (&div_done) c_q <= div_res;
      default: ;
    endcase
    if (finish) begin
      rsp.payload.written_index <= cmd.dest_index;
      rsp.payload.result_x      <= res[0];
      rsp.payload.result_y      <= res[1];
      rsp.payload.result_z      <= res[2];
      rsp.payload.result_w      <= res[3];
    end
  end
endmodule

// ===== design/vector_parameter_op_unit_core.sv =====
// Four-lane Q16.16 vector unit over a 64-entry register file.
// Moves, swizzle, add/sub, compare, logic and table execute directly; mul, dot3 and dot4
// run a multiply state and an accumulate state per lane on one shared 32x32 multiplier,
// and div/mod use 48-step dividers, one per lane.
// One operation is in the back end at a time, and the next starts only after the
// result is registered; the two-entry queue accepts requests ahead.
// Reset (rst, synchronous): all entries read as zero until written, queue empty.
module vector_parameter_op_unit_core import vpou_pkg::*; (
  input logic        clk,
  input logic        rst,
  vpou_req_if.sink   req,
  vpou_rsp_if.source rsp
);
  // front decodes each request into a command: class, effective lane mask,
  // and range flags for the sources and destination
  vpou_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_pop;

  vpou_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // back reads A, B and the old destination from the RAM one after another,
  // executes, merges under the mask, writes back and registers the result
  vpou_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );
endmodule
